// File: rtl/sik_pkg.sv
// Shared constants, request sideband types and the arctangent table of the SCARA
// inverse kinematics pipeline. No dependencies.
package sik_pkg;

  localparam int IFRAC    = 24;  // internal angle fraction bits
  localparam int AW       = 34;  // internal angle width
  localparam int CW       = 45;  // vectoring CORDIC datapath width
  localparam int ROT_W    = 42;  // rotating CORDIC datapath width
  localparam int NORM_MSB = 40;  // vectoring operands normalised to [2^40, 2^41)
  localparam int SHW      = 7;   // normalising shift amount width
  localparam int LEN_W    = 19;
  localparam int POS_W    = 21;
  localparam int SH_W     = 25;
  localparam int EL_W     = 26;
  localparam int PQ_W     = 44;
  localparam int ISQ_RW   = 31;  // root width, radicand is 2*ISQ_RW bits
  localparam int CLW      = 39;  // rotation start value width
  localparam int HD_W     = 44;  // heading operand width

  localparam logic signed [AW-1:0] DEG90        = 34'sd1509949440;
  localparam logic [29:0]          INV_GAIN_Q30 = 30'd652032874;
  localparam logic [6:0]           TOL_OUT      = 7'd107;
  localparam logic [6:0]           TOL_FOLD     = 7'd11;

  localparam logic [1:0] ST_NORMAL  = 2'd0;
  localparam logic [1:0] ST_FOLD    = 2'd1;
  localparam logic [1:0] ST_STRETCH = 2'd2;
  localparam logic [1:0] ST_OUT     = 2'd3;

  localparam logic REG_UPPER_ARM = 1'b0;
  localparam logic REG_FOREARM   = 1'b1;

  typedef struct packed {
    logic [1:0]              status;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic signed [POS_W-1:0] z;
  } item_t;

  typedef struct packed {
    item_t                  it;
    logic signed [PQ_W-1:0] ak;
  } sq_sb_t;

  typedef struct packed {
    item_t                it;
    logic signed [AW-1:0] sh;
  } rot_sb_t;

  typedef struct packed {
    logic                     valid;
    logic [2*ISQ_RW-1:0]      prod;
    sq_sb_t                   sb;
  } front_t;

  // atan(2^-i) in 1/2^24 degree
  function automatic logic [30:0] atan_entry(input int i);
    logic [30:0] v;
    case (i)
      0: v = 31'd754974720;   1: v = 31'd445687602;   2: v = 31'd235489088;
      3: v = 31'd119537938;   4: v = 31'd60000934;    5: v = 31'd30029717;
      6: v = 31'd15018523;    7: v = 31'd7509720;     8: v = 31'd3754917;
      9: v = 31'd1877466;    10: v = 31'd938734;     11: v = 31'd469367;
      12: v = 31'd234684;    13: v = 31'd117342;     14: v = 31'd58671;
      15: v = 31'd29335;     16: v = 31'd14668;      17: v = 31'd7334;
      18: v = 31'd3667;      19: v = 31'd1833;       20: v = 31'd917;
      21: v = 31'd458;       22: v = 31'd229;        23: v = 31'd115;
      24: v = 31'd57;        25: v = 31'd29;         26: v = 31'd14;
      27: v = 31'd7;         28: v = 31'd4;          29: v = 31'd2;
      30: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/sik_front.sv
// Front end: squares, law-of-cosines terms, reach tests and radicand scaling.
// Seven register stages. Depends on sik_pkg.
module sik_front import sik_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  item_t            item_i,
  input  logic [LEN_W-1:0] l1_i,
  input  logic [LEN_W-1:0] l2_i,
  output front_t           front_o
);

  logic [6:0] v_q;
  item_t      it1_q, it2_q, it3_q, it4_q, it5_q, it6_q, it7_q;

  // F1
  logic [40:0] xx_q, yy_q;
  logic [37:0] l1l2_q, l1sq_q, l2sq_q;
  logic [38:0] dd_q;
  logic [39:0] ss_q;
  logic        zl1_q;
  logic signed [41:0] xsq, ysq;
  logic signed [19:0] dl;
  logic signed [39:0] dsq;
  logic [19:0]        sl;

  always_comb begin
    xsq = item_i.x * item_i.x;
    ysq = item_i.y * item_i.y;
    dl  = $signed({1'b0, l1_i}) - $signed({1'b0, l2_i});
    dsq = dl * dl;
    sl  = {1'b0, l1_i} + {1'b0, l2_i};
  end

  always_ff @(posedge clk_i) begin
    it1_q  <= item_i;
    xx_q   <= xsq[40:0];
    yy_q   <= ysq[40:0];
    l1l2_q <= l1_i * l2_i;
    l1sq_q <= l1_i * l1_i;
    l2sq_q <= l2_i * l2_i;
    dd_q   <= dsq[38:0];
    ss_q   <= sl * sl;
    zl1_q  <= (l1_i == '0) || (l2_i == '0);
  end

  // F2
  logic [41:0]        r2_q;
  logic [38:0]        den2_q, dd2_q;
  logic [39:0]        ss2_q;
  logic signed [39:0] lsd2_q;
  logic               zl2_q;

  always_ff @(posedge clk_i) begin
    it2_q  <= it1_q;
    r2_q   <= {1'b0, xx_q} + {1'b0, yy_q};
    den2_q <= {l1l2_q, 1'b0};
    lsd2_q <= $signed({2'b0, l1sq_q}) - $signed({2'b0, l2sq_q});
    dd2_q  <= dd_q;
    ss2_q  <= ss_q;
    zl2_q  <= zl1_q;
  end

  // F3
  logic signed [PQ_W-1:0] p3_q, q3_q, a3_q;
  logic [45:0]            tout3_q, tfold3_q;
  logic [42:0]            pc3_q, qc3_q;
  logic                   zl3_q;
  logic signed [PQ_W-1:0] p_w, q_w;

  always_comb begin
    p_w = $signed({2'b0, r2_q}) - $signed({5'b0, dd2_q});
    q_w = $signed({4'b0, ss2_q}) - $signed({2'b0, r2_q});
  end

  always_ff @(posedge clk_i) begin
    it3_q    <= it2_q;
    p3_q     <= p_w;
    q3_q     <= q_w;
    a3_q     <= $signed({2'b0, r2_q}) + PQ_W'(lsd2_q);
    tout3_q  <= 46'(den2_q) * 46'(TOL_OUT);
    tfold3_q <= 46'(den2_q) * 46'(TOL_FOLD);
    pc3_q    <= (p_w > 0) ? p_w[42:0] : '0;
    qc3_q    <= (q_w > 0) ? q_w[42:0] : '0;
    zl3_q    <= zl2_q;
  end

  // F4: exact tolerance tests, p*2^30 against k*den
  logic signed [75:0]     pw, qw, tneg, tpos, tfp;
  logic                   op4_q, oq4_q, fd4_q, st4_q, zl4_q;
  logic [42:0]            m4_q, pc4_q, qc4_q;
  logic signed [PQ_W-1:0] a4_q;

  always_comb begin
    pw   = 76'(p3_q) <<< 30;
    qw   = 76'(q3_q) <<< 30;
    tpos = $signed(76'(tout3_q));
    tneg = -tpos;
    tfp  = $signed(76'(tfold3_q));
  end

  always_ff @(posedge clk_i) begin
    it4_q <= it3_q;
    op4_q <= pw < tneg;
    oq4_q <= qw < tneg;
    fd4_q <= pw < tfp;
    st4_q <= qw < tpos;
    zl4_q <= zl3_q;
    m4_q  <= (pc3_q > qc3_q) ? pc3_q : qc3_q;
    pc4_q <= pc3_q;
    qc4_q <= qc3_q;
    a4_q  <= a3_q;
  end

  // F5: scale count and case select
  logic [3:0]             k_w, k5_q;
  logic [42:0]            pc5_q, qc5_q;
  logic signed [PQ_W-1:0] a5_q;
  logic [1:0]             st_w;
  item_t                  it5_d;

  always_comb begin
    k_w = '0;
    for (int i = 31; i < 43; i++) begin
      if (m4_q[i]) k_w = 4'(i - 30);
    end
    if (zl4_q || op4_q || oq4_q) st_w = ST_OUT;
    else if (fd4_q)              st_w = ST_FOLD;
    else if (st4_q)              st_w = ST_STRETCH;
    else                         st_w = ST_NORMAL;
    it5_d        = it4_q;
    it5_d.status = st_w;
  end

  always_ff @(posedge clk_i) begin
    it5_q <= it5_d;
    k5_q  <= k_w;
    pc5_q <= pc4_q;
    qc5_q <= qc4_q;
    a5_q  <= a4_q;
  end

  // F6
  logic [ISQ_RW-1:0]      pk6_q, qk6_q;
  logic signed [PQ_W-1:0] ak6_q;
  logic [42:0]            pks, qks;

  always_comb begin
    pks = pc5_q >> k5_q;
    qks = qc5_q >> k5_q;
  end

  always_ff @(posedge clk_i) begin
    it6_q <= it5_q;
    pk6_q <= pks[ISQ_RW-1:0];
    qk6_q <= qks[ISQ_RW-1:0];
    ak6_q <= a5_q >>> k5_q;
  end

  // F7
  logic [2*ISQ_RW-1:0]    prod7_q;
  logic signed [PQ_W-1:0] ak7_q;

  always_ff @(posedge clk_i) begin
    it7_q   <= it6_q;
    prod7_q <= pk6_q * qk6_q;
    ak7_q   <= ak6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], valid_i};
    end
  end

  assign front_o.valid = v_q[6];
  assign front_o.prod  = prod7_q;
  assign front_o.sb.it = it7_q;
  assign front_o.sb.ak = ak7_q;

endmodule

// File: rtl/sik_isqrt.sv
// Pipelined integer square root, one result bit per stage, floor result.
// Depends on sik_pkg.
module sik_isqrt import sik_pkg::*; #(
  parameter int RW = 31,
  parameter int SW = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  logic [2*RW-1:0] v_i,
  input  logic [SW-1:0]   sb_i,
  output logic            valid_o,
  output logic [RW-1:0]   root_o,
  output logic [SW-1:0]   sb_o
);

  localparam int VW = 2*RW + 1;

  logic [VW-1:0] rem_q  [RW+1];
  logic [VW-1:0] root_q [RW+1];
  logic [SW-1:0] sb_q   [RW+1];
  logic [RW:0]   v_q;

  for (genvar g = 0; g <= RW; g++) begin : g_stage
    localparam logic [VW-1:0] BIT = VW'(1) << (2*(RW-g));
    logic [VW-1:0] rem_in, root_in, t;
    logic [SW-1:0] sb_in;
    logic          vin;

    if (g == 0) begin : g_first
      assign rem_in  = VW'(v_i);
      assign root_in = '0;
      assign sb_in   = sb_i;
      assign vin     = valid_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign sb_in   = sb_q[g-1];
      assign vin     = v_q[g-1];
    end

    assign t = root_in + BIT;

    always_ff @(posedge clk_i) begin
      sb_q[g] <= sb_in;
      if (rem_in >= t) begin
        rem_q[g]  <= rem_in - t;
        root_q[g] <= (root_in >> 1) + BIT;
      end else begin
        rem_q[g]  <= rem_in;
        root_q[g] <= root_in >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else begin
        v_q[g] <= vin;
      end
    end
  end

  assign valid_o = v_q[RW];
  assign root_o  = root_q[RW][RW-1:0];
  assign sb_o    = sb_q[RW];

endmodule

// File: rtl/sik_atan2.sv
// Pipelined vectoring CORDIC atan2: three normalising stages, a quadrant stage,
// then one register stage per micro-rotation. Depends on sik_pkg.
module sik_atan2 import sik_pkg::*; #(
  parameter int IW     = 44,
  parameter int SW     = 1,
  parameter int NSTAGE = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  input  logic signed [IW-1:0] y_i,
  input  logic signed [IW-1:0] x_i,
  input  logic [SW-1:0]        sb_i,
  output logic                 valid_o,
  output logic signed [AW-1:0] z_o,
  output logic [SW-1:0]        sb_o
);

  logic [2:0] nv_q;

  // N1: magnitude
  logic signed [IW-1:0] x1_q, y1_q;
  logic [IW-1:0]        m1_q, ax, ay;
  logic                 zr1_q;
  logic [SW-1:0]        sb1_q;

  always_comb begin
    ax = x_i[IW-1] ? IW'(-x_i) : IW'(x_i);
    ay = y_i[IW-1] ? IW'(-y_i) : IW'(y_i);
  end

  always_ff @(posedge clk_i) begin
    x1_q  <= x_i;
    y1_q  <= y_i;
    m1_q  <= (ax > ay) ? ax : ay;
    zr1_q <= (x_i == '0) && (y_i == '0);
    sb1_q <= sb_i;
  end

  // N2: leading one and shift amounts
  logic signed [IW-1:0] x2_q, y2_q;
  logic [SHW-1:0]       ls2_q, rs2_q, msb;
  logic                 zr2_q;
  logic [SW-1:0]        sb2_q;

  always_comb begin
    msb = '0;
    for (int i = 0; i < IW; i++) begin
      if (m1_q[i]) msb = SHW'(i);
    end
  end

  always_ff @(posedge clk_i) begin
    x2_q  <= x1_q;
    y2_q  <= y1_q;
    ls2_q <= (msb < SHW'(NORM_MSB)) ? SHW'(NORM_MSB) - msb : '0;
    rs2_q <= (msb > SHW'(NORM_MSB)) ? msb - SHW'(NORM_MSB) : '0;
    zr2_q <= zr1_q;
    sb2_q <= sb1_q;
  end

  // N3: shift
  logic signed [CW-1:0] x3_q, y3_q, xe, ye;
  logic                 zr3_q;
  logic [SW-1:0]        sb3_q;

  always_comb begin
    xe = CW'(x2_q);
    ye = CW'(y2_q);
  end

  always_ff @(posedge clk_i) begin
    x3_q  <= (xe <<< ls2_q) >>> rs2_q;
    y3_q  <= (ye <<< ls2_q) >>> rs2_q;
    zr3_q <= zr2_q;
    sb3_q <= sb2_q;
  end

  // N4 and micro-rotations
  logic signed [CW-1:0] cx_q [NSTAGE+1];
  logic signed [CW-1:0] cy_q [NSTAGE+1];
  logic signed [AW-1:0] cz_q [NSTAGE+1];
  logic [NSTAGE:0]      zr_q;
  logic [SW-1:0]        sb_q [NSTAGE+1];
  logic [NSTAGE:0]      cv_q;

  always_ff @(posedge clk_i) begin
    zr_q[0] <= zr3_q;
    sb_q[0] <= sb3_q;
    if (x3_q < 0) begin
      if (y3_q >= 0) begin
        cx_q[0] <= y3_q;
        cy_q[0] <= -x3_q;
        cz_q[0] <= DEG90;
      end else begin
        cx_q[0] <= -y3_q;
        cy_q[0] <= x3_q;
        cz_q[0] <= -DEG90;
      end
    end else begin
      cx_q[0] <= x3_q;
      cy_q[0] <= y3_q;
      cz_q[0] <= '0;
    end
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_rot
    localparam logic signed [AW-1:0] ANG = AW'($signed({1'b0, atan_entry(g)}));
    always_ff @(posedge clk_i) begin
      zr_q[g+1] <= zr_q[g];
      sb_q[g+1] <= sb_q[g];
      if (cy_q[g] > 0) begin
        cx_q[g+1] <= cx_q[g] + (cy_q[g] >>> g);
        cy_q[g+1] <= cy_q[g] - (cx_q[g] >>> g);
        cz_q[g+1] <= cz_q[g] + ANG;
      end else begin
        cx_q[g+1] <= cx_q[g] - (cy_q[g] >>> g);
        cy_q[g+1] <= cy_q[g] + (cx_q[g] >>> g);
        cz_q[g+1] <= cz_q[g] - ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q <= '0;
      cv_q <= '0;
    end else begin
      nv_q <= {nv_q[1:0], valid_i};
      cv_q <= {cv_q[NSTAGE-1:0], nv_q[2]};
    end
  end

  assign valid_o = cv_q[NSTAGE];
  assign z_o     = zr_q[NSTAGE] ? '0 : cz_q[NSTAGE];
  assign sb_o    = sb_q[NSTAGE];

endmodule

// File: rtl/sik_rotate.sv
// Pipelined rotating CORDIC: quadrant stage then one stage per micro-rotation;
// gives the cosine and sine of the angle scaled by the start value. Depends on sik_pkg.
module sik_rotate import sik_pkg::*; #(
  parameter int SW     = 1,
  parameter int NSTAGE = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    valid_i,
  input  logic [CLW-1:0]          c_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic [SW-1:0]           sb_i,
  output logic                    valid_o,
  output logic signed [ROT_W-1:0] x_o,
  output logic signed [ROT_W-1:0] y_o,
  output logic [SW-1:0]           sb_o
);

  logic signed [ROT_W-1:0] rx_q [NSTAGE+1];
  logic signed [ROT_W-1:0] ry_q [NSTAGE+1];
  logic signed [AW-1:0]    ra_q [NSTAGE+1];
  logic [SW-1:0]           sb_q [NSTAGE+1];
  logic [NSTAGE:0]         v_q;
  logic signed [ROT_W-1:0] ce;

  assign ce = $signed(ROT_W'(c_i));

  always_ff @(posedge clk_i) begin
    sb_q[0] <= sb_i;
    if (a_i > DEG90) begin
      rx_q[0] <= '0;
      ry_q[0] <= ce;
      ra_q[0] <= a_i - DEG90;
    end else if (a_i < -DEG90) begin
      rx_q[0] <= '0;
      ry_q[0] <= -ce;
      ra_q[0] <= a_i + DEG90;
    end else begin
      rx_q[0] <= ce;
      ry_q[0] <= '0;
      ra_q[0] <= a_i;
    end
  end

  for (genvar g = 0; g < NSTAGE; g++) begin : g_rot
    localparam logic signed [AW-1:0] ANG = AW'($signed({1'b0, atan_entry(g)}));
    always_ff @(posedge clk_i) begin
      sb_q[g+1] <= sb_q[g];
      if (ra_q[g] >= 0) begin
        rx_q[g+1] <= rx_q[g] - (ry_q[g] >>> g);
        ry_q[g+1] <= ry_q[g] + (rx_q[g] >>> g);
        ra_q[g+1] <= ra_q[g] - ANG;
      end else begin
        rx_q[g+1] <= rx_q[g] + (ry_q[g] >>> g);
        ry_q[g+1] <= ry_q[g] - (rx_q[g] >>> g);
        ra_q[g+1] <= ra_q[g] + ANG;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[NSTAGE-1:0], valid_i};
    end
  end

  assign valid_o = v_q[NSTAGE];
  assign x_o     = rx_q[NSTAGE];
  assign y_o     = ry_q[NSTAGE];
  assign sb_o    = sb_q[NSTAGE];

endmodule

// File: rtl/scara_inverse_kinematics_top.sv
// Top level of the two-link SCARA inverse kinematics pipeline.
// Depends on sik_pkg, sik_front, sik_isqrt, sik_atan2 and sik_rotate.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  request   goal_x_i, goal_y_i, goal_z_i            start_i high, busy_o low
//  result    solve_status_o, shoulder_angle_o,       done_o high for one cycle
//            elbow_angle_o, lift_position_o
//  config    cfg_idx_i, cfg_wdata_i                  cfg_we_i high, no wait
//
// One request per cycle, every cycle; busy_o stays low.
// The pipeline is made of seven front stages, a 32-stage square root, three
// vectoring/rotating CORDIC passes of 4, 1 and 4 set-up stages plus one stage per
// micro-rotation, and four glue stages.
// Reset clears every valid bit and loads the default link lengths.
// The receiver cannot stall, so nothing here ever holds a request back.
module scara_inverse_kinematics_top import sik_pkg::*; #(
  parameter int ANGLE_FRAC_BITS = 16,
  parameter int CORDIC_STAGES   = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  output logic                    busy_o,
  input  logic signed [POS_W-1:0] goal_x_i,
  input  logic signed [POS_W-1:0] goal_y_i,
  input  logic signed [POS_W-1:0] goal_z_i,
  output logic                    done_o,
  output logic [1:0]              solve_status_o,
  output logic signed [SH_W-1:0]  shoulder_angle_o,
  output logic signed [EL_W-1:0]  elbow_angle_o,
  output logic signed [POS_W-1:0] lift_position_o,
  input  logic                    cfg_we_i,
  input  logic                    cfg_idx_i,
  input  logic [LEN_W-1:0]        cfg_wdata_i
);

  localparam int NSTAGE = (CORDIC_STAGES < 32) ? CORDIC_STAGES : 32;
  localparam int SH     = IFRAC - ANGLE_FRAC_BITS;    // output rounding shift
  localparam logic signed [AW+1:0] RND  = (AW+2)'(1) <<< (SH - 1);
  localparam logic signed [AW+1:0] HALF = (AW+2)'(180) <<< ANGLE_FRAC_BITS;

  // link lengths; the user must write them only while the pipe is empty, the block does not enforce it
  logic [LEN_W-1:0] l1_q, l2_q;
  logic [CLW-1:0]   c_q;
  logic [48:0]      c_prod;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l1_q <= LEN_W'(256000);
      l2_q <= LEN_W'(153600);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_UPPER_ARM) l1_q <= cfg_wdata_i;
      if (cfg_idx_i == REG_FOREARM)   l2_q <= cfg_wdata_i;
    end
  end

  // rotation start value: l1 / CORDIC gain, in 2^-20 units of l1
  assign c_prod = 49'(l1_q) * 49'(INV_GAIN_Q30);
  always_ff @(posedge clk_i) begin
    c_q <= c_prod[10 +: CLW];
  end

  assign busy_o = 1'b0;

  // front end
  item_t  in_item;
  front_t fr;

  always_comb begin
    in_item.status = ST_NORMAL;
    in_item.x      = goal_x_i;
    in_item.y      = goal_y_i;
    in_item.z      = goal_z_i;
  end

  sik_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i && !busy_o),
    .item_i  (in_item),
    .l1_i    (l1_q),
    .l2_i    (l2_q),
    .front_o (fr)
  );

  // sqrt(P*Q) gives the sine term of the shoulder offset
  logic              sq_v;
  logic [ISQ_RW-1:0] sq_root;
  sq_sb_t            sq_sb;

  sik_isqrt #(.RW(ISQ_RW), .SW($bits(sq_sb_t))) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr.valid),
    .v_i     (fr.prod),
    .sb_i    (fr.sb),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .sb_o    (sq_sb)
  );

  // goal bearing and shoulder offset, side by side with equal latency
  logic                 at_v;
  logic signed [AW-1:0] bear_z, offs_z;
  item_t                at_it;

  sik_atan2 #(.IW(POS_W), .SW($bits(item_t)), .NSTAGE(NSTAGE)) u_bearing (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .y_i     (sq_sb.it.y),
    .x_i     (sq_sb.it.x),
    .sb_i    (sq_sb.it),
    .valid_o (at_v),
    .z_o     (bear_z),
    .sb_o    (at_it)
  );

  sik_atan2 #(.IW(PQ_W), .SW(1), .NSTAGE(NSTAGE)) u_offset (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sq_v),
    .y_i     ($signed(PQ_W'(sq_root))),
    .x_i     (sq_sb.ak),
    .sb_i    (1'b0),
    .valid_o (),
    .z_o     (offs_z),
    .sb_o    ()
  );

  // S1: shoulder in internal units
  logic                 s1_v_q;
  logic signed [AW:0]   ang1_q;
  item_t                s1_it_q;

  always_ff @(posedge clk_i) begin
    s1_it_q <= at_it;
    if (at_it.status == ST_NORMAL) ang1_q <= (AW+1)'(bear_z) - (AW+1)'(offs_z);
    else                           ang1_q <= (AW+1)'(bear_z);
  end

  // S2: round to output units and wrap into (-180, 180]
  logic                 s2_v_q;
  logic signed [AW-1:0] sh1_q;
  item_t                s2_it_q;
  logic signed [AW+1:0] rnd1, wr1;

  always_comb begin
    rnd1 = ((AW+2)'(ang1_q) + RND) >>> SH;
    if (rnd1 <= -HALF)    wr1 = rnd1 + (HALF <<< 1);
    else if (rnd1 > HALF) wr1 = rnd1 - (HALF <<< 1);
    else                  wr1 = rnd1;
  end

  always_ff @(posedge clk_i) begin
    s2_it_q <= s1_it_q;
    sh1_q   <= AW'(wr1);
  end

  // upper arm tip from the rounded shoulder
  logic                    ro_v;
  logic signed [ROT_W-1:0] tip_x, tip_y;
  rot_sb_t                 ro_in, ro_sb;

  assign ro_in.it = s2_it_q;
  assign ro_in.sh = sh1_q;

  sik_rotate #(.SW($bits(rot_sb_t)), .NSTAGE(NSTAGE)) u_rotate (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_v_q),
    .c_i     (c_q),
    .a_i     (sh1_q <<< SH),
    .sb_i    (ro_in),
    .valid_o (ro_v),
    .x_o     (tip_x),
    .y_o     (tip_y),
    .sb_o    (ro_sb)
  );

  // H1: forearm vector, goal minus tip in 2^-20 units
  logic                   h1_v_q;
  logic signed [HD_W-1:0] hx_q, hy_q;
  rot_sb_t                h1_sb_q;

  always_ff @(posedge clk_i) begin
    h1_sb_q <= ro_sb;
    hx_q    <= (HD_W'(ro_sb.it.x) <<< 20) - HD_W'(tip_x);
    hy_q    <= (HD_W'(ro_sb.it.y) <<< 20) - HD_W'(tip_y);
  end

  logic                 hd_v;
  logic signed [AW-1:0] head_z;
  rot_sb_t              hd_sb;

  sik_atan2 #(.IW(HD_W), .SW($bits(rot_sb_t)), .NSTAGE(NSTAGE)) u_heading (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (h1_v_q),
    .y_i     (hy_q),
    .x_i     (hx_q),
    .sb_i    (h1_sb_q),
    .valid_o (hd_v),
    .z_o     (head_z),
    .sb_o    (hd_sb)
  );

  // output stage: elbow = heading - shoulder, then case select
  logic                   done_q;
  logic [1:0]             st_q;
  logic signed [SH_W-1:0] sh_q;
  logic signed [EL_W-1:0] el_q;
  logic signed [POS_W-1:0] lift_q;
  logic signed [AW+1:0]   head_r;
  logic signed [AW-1:0]   elb;

  always_comb begin
    head_r = ((AW+2)'(head_z) + RND) >>> SH;
    elb    = AW'(head_r) - hd_sb.sh;
  end

  always_ff @(posedge clk_i) begin
    st_q   <= hd_sb.it.status;
    lift_q <= hd_sb.it.z;
    case (hd_sb.it.status)
      ST_NORMAL: begin
        sh_q <= SH_W'(hd_sb.sh);
        el_q <= EL_W'(elb);
      end
      ST_FOLD: begin
        sh_q <= SH_W'(hd_sb.sh);
        el_q <= EL_W'(HALF);
      end
      ST_STRETCH: begin
        sh_q <= SH_W'(hd_sb.sh);
        el_q <= '0;
      end
      default: begin
        sh_q <= '0;
        el_q <= '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      h1_v_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      s1_v_q <= at_v;
      s2_v_q <= s1_v_q;
      h1_v_q <= ro_v;
      done_q <= hd_v;
    end
  end

  assign done_o           = done_q;
  assign solve_status_o   = st_q;
  assign shoulder_angle_o = sh_q;
  assign elbow_angle_o    = el_q;
  assign lift_position_o  = lift_q;

  // wrapped shoulder always lands in (-180, 180]
  a_sh_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_v_q |-> ((AW+2)'(sh1_q) > -HALF) && ((AW+2)'(sh1_q) <= HALF))
    else $error("shoulder outside wrap range");

  a_out_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (solve_status_o == ST_OUT)) |->
      (shoulder_angle_o == '0) && (elbow_angle_o == '0))
    else $error("out of reach result carries angles");

  a_fold_elb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (solve_status_o == ST_FOLD)) |-> (elbow_angle_o == EL_W'(HALF)))
    else $error("folded result elbow not 180 degrees");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for scara_inverse_kinematics_top.
// Predicts each result with a bit-true integer model of the joint solver. Depends on sik_pkg.
`timescale 1ns / 1ps

module testbench import sik_pkg::*; ();

  // Clock and reset
  logic clk_i;
  logic rst_ni;

  // Request channel
  logic                    start_i;
  logic                    busy_o;
  logic signed [POS_W-1:0] goal_x_i;
  logic signed [POS_W-1:0] goal_y_i;
  logic signed [POS_W-1:0] goal_z_i;

  // Result channel
  logic                    done_o;
  logic [1:0]              solve_status_o;
  logic signed [SH_W-1:0]  shoulder_angle_o;
  logic signed [EL_W-1:0]  elbow_angle_o;
  logic signed [POS_W-1:0] lift_position_o;

  // Config port
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [LEN_W-1:0] cfg_wdata_i;

  localparam int  TB_ANGLE_FRAC = 16;
  localparam int  TB_STAGES     = 24;
  localparam int  TB_IFRAC      = 24;
  localparam int  LATENCY       = 52 + 3 * TB_STAGES;
  localparam int  CYCLE_LIMIT   = 400000;
  localparam longint TB_DEG90   = longint'(90) <<< TB_IFRAC;
  localparam real PI            = 3.14159265358979;

  // atan(2^-i), 1/2^24 degree
  localparam longint ATAN_LUT [32] = '{
    754974720, 445687602, 235489088, 119537938, 60000934, 30029717,
    15018523, 7509720, 3754917, 1877466, 938734, 469367, 234684, 117342,
    58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29,
    14, 7, 4, 2, 1, 0
  };

  typedef struct packed {
    logic [1:0]              status;
    logic signed [SH_W-1:0]  shoulder;
    logic signed [EL_W-1:0]  elbow;
    logic signed [POS_W-1:0] lift;
  } joint_goal_t;

  typedef struct {
    int          x;
    int          y;
    int          z;
    bit          typed;   // expected result given in the row
    joint_goal_t goal;
  } goal_row_t;

  joint_goal_t pending_goals[$];
  longint      arm_l1;
  longint      arm_l2;
  int          errors;
  int          cycles;
  int          idle_pct;

  scara_inverse_kinematics_top u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .goal_x_i         (goal_x_i),
    .goal_y_i         (goal_y_i),
    .goal_z_i         (goal_z_i),
    .done_o           (done_o),
    .solve_status_o   (solve_status_o),
    .shoulder_angle_o (shoulder_angle_o),
    .elbow_angle_o    (elbow_angle_o),
    .lift_position_o  (lift_position_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Integer joint solver
  // ---------------------------------------------------------------------------

  // v * 2^30 < t without overflow
  function automatic bit scaled_below(longint v, longint t);
    if (v >= (longint'(1) <<< 17)) return 1'b0;
    if (v <= -(longint'(1) <<< 17)) return 1'b1;
    return (v * (longint'(1) <<< 30)) < t;
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned v);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= root + bitv) begin
        v    = v - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint unsigned m;
    longint ang, t, nx, ny;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    m = mag(x) > mag(y) ? mag(x) : mag(y);
    while (m >= (64'd1 << 41)) begin
      x = x >>> 1;
      y = y >>> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 40)) begin
      x = x * 2;
      y = y * 2;
      m = m << 1;
    end
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;   y = -t; ang = TB_DEG90;
      end else begin
        x = -y;  y = t;  ang = -TB_DEG90;
      end
    end
    for (int i = 0; i < TB_STAGES; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i); ny = y - (x >>> i); ang = ang + ATAN_LUT[i];
      end else begin
        nx = x - (y >>> i); ny = y + (x >>> i); ang = ang - ATAN_LUT[i];
      end
      x = nx;
      y = ny;
    end
    return ang;
  endfunction

  function automatic void rotate_len(longint c, longint a, output longint cx,
                                     output longint sy);
    longint x, y, nx, ny;
    x = c;
    y = 0;
    if (a > TB_DEG90) begin
      x = 0; y = c;  a = a - TB_DEG90;
    end else if (a < -TB_DEG90) begin
      x = 0; y = -c; a = a + TB_DEG90;
    end
    for (int i = 0; i < TB_STAGES; i++) begin
      if (a >= 0) begin
        nx = x - (y >>> i); ny = y + (x >>> i); a = a - ATAN_LUT[i];
      end else begin
        nx = x + (y >>> i); ny = y - (x >>> i); a = a + ATAN_LUT[i];
      end
      x = nx;
      y = ny;
    end
    cx = x;
    sy = y;
  endfunction

  function automatic longint round_angle(longint v);
    int s;
    s = TB_IFRAC - TB_ANGLE_FRAC;
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic longint wrap_half_turn(longint a);
    longint half;
    half = longint'(180) <<< TB_ANGLE_FRAC;
    if (a <= -half) a = a + 2 * half;
    else if (a > half) a = a - 2 * half;
    return a;
  endfunction

  function automatic joint_goal_t solve_joints(int gx, int gy, int gz);
    joint_goal_t res;
    longint x, y, den, r, p, q, d, s, sh, el, a, b, t11, lx, ly, head, c;
    longint unsigned pc, qc, m;
    int k;
    x  = gx;
    y  = gy;
    sh = 0;
    el = 0;
    den = 2 * arm_l1 * arm_l2;
    r   = x * x + y * y;
    d   = arm_l1 - arm_l2;
    s   = arm_l1 + arm_l2;
    p   = r - d * d;
    q   = s * s - r;
    if (den == 0 || scaled_below(p, -longint'(TOL_OUT) * den) ||
        scaled_below(q, -longint'(TOL_OUT) * den)) begin
      res.status = ST_OUT;
    end else if (scaled_below(p, longint'(TOL_FOLD) * den)) begin
      res.status = ST_FOLD;
      sh = wrap_half_turn(round_angle(vector_angle(y, x)));
      el = longint'(180) <<< TB_ANGLE_FRAC;
    end else if (scaled_below(q, longint'(TOL_OUT) * den)) begin
      res.status = ST_STRETCH;
      sh = wrap_half_turn(round_angle(vector_angle(y, x)));
    end else begin
      res.status = ST_NORMAL;
      a  = r + arm_l1 * arm_l1 - arm_l2 * arm_l2;
      pc = p > 0 ? p : 0;
      qc = q > 0 ? q : 0;
      m  = pc > qc ? pc : qc;
      k  = 0;
      while ((m >> k) >= (64'd1 << 31)) k++;
      b   = floor_sqrt((pc >> k) * (qc >> k));
      t11 = vector_angle(b, a >>> k);
      sh  = wrap_half_turn(round_angle(vector_angle(y, x) - t11));
      c   = (arm_l1 * 652032874) >>> 10;
      rotate_len(c, sh * (longint'(1) <<< (TB_IFRAC - TB_ANGLE_FRAC)), lx, ly);
      head = round_angle(vector_angle(y * (longint'(1) <<< 20) - ly,
                                      x * (longint'(1) <<< 20) - lx));
      el = head - sh;
    end
    res.shoulder = sh[SH_W-1:0];
    res.elbow    = el[EL_W-1:0];
    res.lift     = gz[POS_W-1:0];
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // write enable drops after the edge that takes the write; the task waits another edge before returning
  task automatic write_length(logic idx, logic [LEN_W-1:0] len);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= len;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_UPPER_ARM) arm_l1 = len;
    else arm_l2 = len;
    @(posedge clk_i);
  endtask

  // Pushes the typed goal if given, else the predicted one. start_i stays high
  // afterwards; the gap logic lowers it only when the sender idles.
  task automatic send_goal(int x, int y, int z, bit typed, joint_goal_t goal);
    bit busy_seen;
    start_i  <= 1'b1;
    goal_x_i <= x[POS_W-1:0];
    goal_y_i <= y[POS_W-1:0];
    goal_z_i <= z[POS_W-1:0];
    do begin
      @(negedge clk_i);
      busy_seen = busy_o;
      @(posedge clk_i);
    end while (busy_seen);
    pending_goals.push_back(typed ? goal : solve_joints(x, y, z));
    if ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_results();
    start_i <= 1'b0;
    while (pending_goals.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic int clamp_pos(longint v);
    if (v > 1048575) return 1048575;
    if (v < -1048576) return -1048576;
    return int'(v);
  endfunction

  // Mostly points inside the annulus, some on its rims, the rest noise
  task automatic random_goals(int count);
    joint_goal_t none;
    real lo, hi, rad, th;
    int x, y, z, kind;
    none = '0;
    lo = (arm_l1 > arm_l2) ? real'(arm_l1 - arm_l2) : real'(arm_l2 - arm_l1);
    hi = real'(arm_l1 + arm_l2);
    for (int n = 0; n < count; n++) begin
      kind = $urandom_range(0, 99);
      z    = int'($urandom_range(0, 2097151)) - 1048576;
      if (kind < 70) begin
        th  = real'($urandom_range(0, 359999)) / 1000.0 * PI / 180.0;
        rad = lo + (hi - lo) * real'($urandom_range(0, 1000000)) / 1000000.0;
        x   = clamp_pos($rtoi(rad * $cos(th)));
        y   = clamp_pos($rtoi(rad * $sin(th)));
      end else if (kind < 85) begin
        // rims along an axis, nudged by a few units
        rad = ($urandom_range(0, 1) != 0) ? hi : lo;
        x   = clamp_pos($rtoi(rad) + int'($urandom_range(0, 6)) - 3);
        y   = int'($urandom_range(0, 6)) - 3;
        if ($urandom_range(0, 1) != 0) begin
          y = x; x = int'($urandom_range(0, 6)) - 3;
        end
        if ($urandom_range(0, 1) != 0) x = -x;
        if ($urandom_range(0, 1) != 0) y = -y;
        x = clamp_pos(x);
        y = clamp_pos(y);
      end else begin
        x = int'($urandom_range(0, 2097151)) - 1048576;
        y = int'($urandom_range(0, 2097151)) - 1048576;
      end
      send_goal(x, y, z, 1'b0, none);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: done_o sampled at the edge ending its cycle
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    joint_goal_t want;
    if (rst_ni && done_o) begin
      if (pending_goals.size() == 0) begin
        report_mismatch("unexpected result", solve_status_o, -1);
      end else begin
        want = pending_goals.pop_front();
        if (solve_status_o !== want.status)
          report_mismatch("solve_status", solve_status_o, want.status);
        if (shoulder_angle_o !== want.shoulder)
          report_mismatch("shoulder_angle", shoulder_angle_o, want.shoulder);
        if (elbow_angle_o !== want.elbow)
          report_mismatch("elbow_angle", elbow_angle_o, want.elbow);
        if (lift_position_o !== want.lift)
          report_mismatch("lift_position", lift_position_o, want.lift);
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL scara_inverse_kinematics_top");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    goal_row_t   rows[$];
    goal_row_t   row;
    joint_goal_t unreach;
    int          lengths[8][2];

    errors      = 0;
    cycles      = 0;
    idle_pct    = 0;
    arm_l1      = 256000;
    arm_l2      = 153600;
    rst_ni      = 1'b0;
    start_i     = 1'b0;
    goal_x_i    = '0;
    goal_y_i    = '0;
    goal_z_i    = '0;
    cfg_we_i    = 1'b0;
    cfg_idx_i   = REG_UPPER_ARM;
    cfg_wdata_i = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows against the reset lengths (250 mm / 150 mm)
    unreach = '{status: ST_OUT, shoulder: '0, elbow: '0, lift: '0};
    row = '{x: 0, y: 0, z: 0, typed: 1'b1, goal: unreach};
    rows.push_back(row);                                   // atan2 of origin, unreachable
    row = '{x: 1048575, y: 1048575, z: 1048575, typed: 1'b1, goal: unreach};
    row.goal.lift = 21'sd1048575;
    rows.push_back(row);
    row = '{x: -1048576, y: -1048576, z: -1048576, typed: 1'b1, goal: unreach};
    row.goal.lift = -21'sd1048575 - 21'sd1;
    rows.push_back(row);
    row = '{x: -1048575, y: 0, z: -1048575, typed: 1'b1, goal: unreach};
    row.goal.lift = -21'sd1048575;
    rows.push_back(row);
    row.typed = 1'b0;
    row.x = 409600;  row.y = 0;       row.z = 7;   rows.push_back(row);  // stretched
    row.x = -409600; row.y = 0;       row.z = -7;  rows.push_back(row);  // stretched, 180
    row.x = 0;       row.y = 409600;  row.z = 1;   rows.push_back(row);
    row.x = 0;       row.y = -409600; row.z = 2;   rows.push_back(row);
    row.x = 102400;  row.y = 0;       row.z = 3;   rows.push_back(row);  // folded
    row.x = -102400; row.y = 0;       row.z = 4;   rows.push_back(row);
    row.x = 0;       row.y = -102400; row.z = 5;   rows.push_back(row);
    row.x = 409601;  row.y = 0;       row.z = 6;   rows.push_back(row);  // just past reach
    row.x = 102399;  row.y = 0;       row.z = 8;   rows.push_back(row);  // just inside hole
    row.x = 300000;  row.y = 0;       row.z = 9;   rows.push_back(row);  // normal
    row.x = -200000; row.y = 150000;  row.z = 10;  rows.push_back(row);
    row.x = -200000; row.y = -150000; row.z = 11;  rows.push_back(row);
    row.x = -300000; row.y = -1;      row.z = 12;  rows.push_back(row);  // shoulder wraps
    row.x = -300000; row.y = 1;       row.z = 13;  rows.push_back(row);
    row.x = 250000;  row.y = 150000;  row.z = 0;   rows.push_back(row);
    foreach (rows[i]) send_goal(rows[i].x, rows[i].y, rows[i].z, rows[i].typed, rows[i].goal);
    drain_results();

    // Length settings: default, extremes, lopsided, zero, random
    lengths = '{'{256000, 153600}, '{1, 1}, '{524287, 524287}, '{524287, 1},
                '{1, 524287}, '{0, 1000}, '{300000, 0}, '{0, 0}};
    lengths[7][0] = $urandom_range(1000, 524287);
    lengths[7][1] = $urandom_range(1000, 524287);
    for (int ph = 0; ph < 8; ph++) begin
      // idling phases cycle through none, 59, none (receiver cannot stall), 29
      case (ph % 4)
        0:       idle_pct = 0;
        1:       idle_pct = 59;
        2:       idle_pct = 0;
        default: idle_pct = 29;
      endcase
      write_length(REG_UPPER_ARM, LEN_W'(lengths[ph][0]));
      write_length(REG_FOREARM, LEN_W'(lengths[ph][1]));
      random_goals(ph < 5 ? 220 : 150);
      drain_results();
    end
    // and some random-length phases with random idling
    for (int ph = 0; ph < 2; ph++) begin
      idle_pct = (ph == 0) ? 59 : 29;
      write_length(REG_UPPER_ARM, LEN_W'($urandom_range(1, 524287)));
      write_length(REG_FOREARM, LEN_W'($urandom_range(1, 524287)));
      random_goals(60);
      drain_results();
    end

    repeat (LATENCY + 8) @(posedge clk_i);
    if (errors == 0 && pending_goals.size() == 0) begin
      $display("PASS scara_inverse_kinematics_top");
    end else begin
      $display("FAIL scara_inverse_kinematics_top");
    end
    $finish;
  end

endmodule
